@@ rtl/core/tpq_pkg.sv @@
`default_nettype none

package tpq_pkg;

  // Result codes carried on status_o
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_DROPPED  = 2'd3
  } status_e;

  // Operation codes carried on mode_i
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // Threshold after reset: values at or above it go to the priority class
  localparam logic signed [31:0] THRESH_RESET = 32'sd60;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } ctrl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic exec;   // run the accepted word this cycle
    logic resp;   // result registers are on the ports
  } tpq_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/tpq_ctrl.sv @@
`default_nettype none

module tpq_ctrl
  import tpq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  output tpq_cmd_t      cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o.exec = 1'b0;
    cmd_o.resp = 1'b0;
    busy_o     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.exec = 1'b1;
          state_d    = S_RESP;
        end
      end
      S_RESP: begin
        busy_o     = 1'b1;
        cmd_o.resp = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign done_o = cmd_o.resp;

  a_exec_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> (state_q == S_RESP))
    else $error("accepted word not followed by a response cycle");

  a_resp_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) |=> (state_q == S_IDLE))
    else $error("response cycle lasted more than one clock");

  a_no_exec_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !cmd_o.exec)
    else $error("word executed while busy");

endmodule

`default_nettype wire

@@ rtl/core/tpq_datapath.sv @@
`default_nettype none

module tpq_datapath
  import tpq_pkg::*;
#(
  parameter int CLASS_DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tpq_cmd_t           cmd_i,
  input  wire logic               mode_i,
  input  wire logic signed [31:0] item_value_i,
  input  wire logic               cfg_we_i,
  input  wire logic signed [31:0] cfg_wdata_i,
  output logic [1:0]              status_o,
  output logic signed [31:0]      out_value_o,
  output logic                    out_was_priority_o
);

  localparam int PtrW = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
  localparam int CntW = $clog2(CLASS_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(CLASS_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(CLASS_DEPTH);

  logic signed [31:0] thresh_q;
  logic [PtrW-1:0]    p_head_q, p_head_d, p_tail_q, p_tail_d;
  logic [PtrW-1:0]    n_head_q, n_head_d, n_tail_q, n_tail_d;
  logic [CntW-1:0]    p_count_q, p_count_d, n_count_q, n_count_d;
  status_e            status_q, status_d;
  logic               was_prio_q, was_prio_d;

  logic [31:0] p_mem [CLASS_DEPTH];
  logic [31:0] n_mem [CLASS_DEPTH];
  logic [31:0] p_rdata_q, n_rdata_q;

  logic is_prio, p_full, n_full, p_any, n_any;
  logic p_wr, n_wr, p_rd, n_rd;

  // Classify and decode the accepted word
  assign is_prio = (item_value_i >= thresh_q);
  assign p_full  = (p_count_q == CntFull);
  assign n_full  = (n_count_q == CntFull);
  assign p_any   = (p_count_q != '0);
  assign n_any   = (n_count_q != '0);

  assign p_wr = cmd_i.exec && (mode_i == MODE_INSERT) && is_prio && !p_full;
  assign n_wr = cmd_i.exec && (mode_i == MODE_INSERT) && !is_prio && !n_full;
  assign p_rd = cmd_i.exec && (mode_i == MODE_REMOVE) && p_any;
  assign n_rd = cmd_i.exec && (mode_i == MODE_REMOVE) && !p_any && n_any;

  // Pointer, count and result updates
  always_comb begin
    p_head_d   = p_head_q;
    p_tail_d   = p_tail_q;
    n_head_d   = n_head_q;
    n_tail_d   = n_tail_q;
    p_count_d  = p_count_q;
    n_count_d  = n_count_q;
    status_d   = status_q;
    was_prio_d = was_prio_q;
    if (p_wr) begin
      p_tail_d  = (p_tail_q == PtrLast) ? '0 : p_tail_q + 1'b1;
      p_count_d = p_count_q + 1'b1;
    end
    if (n_wr) begin
      n_tail_d  = (n_tail_q == PtrLast) ? '0 : n_tail_q + 1'b1;
      n_count_d = n_count_q + 1'b1;
    end
    if (p_rd) begin
      p_head_d  = (p_head_q == PtrLast) ? '0 : p_head_q + 1'b1;
      p_count_d = p_count_q - 1'b1;
    end
    if (n_rd) begin
      n_head_d  = (n_head_q == PtrLast) ? '0 : n_head_q + 1'b1;
      n_count_d = n_count_q - 1'b1;
    end
    if (cmd_i.exec) begin
      if (mode_i == MODE_INSERT) begin
        was_prio_d = is_prio;
        status_d   = (p_wr || n_wr) ? ST_INSERTED : ST_DROPPED;
      end else begin
        was_prio_d = p_any;
        status_d   = (p_any || n_any) ? ST_REMOVED : ST_EMPTY;
      end
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q   <= THRESH_RESET;
      p_head_q   <= '0;
      p_tail_q   <= '0;
      n_head_q   <= '0;
      n_tail_q   <= '0;
      p_count_q  <= '0;
      n_count_q  <= '0;
      status_q   <= ST_INSERTED;
      was_prio_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
      p_head_q   <= p_head_d;
      p_tail_q   <= p_tail_d;
      n_head_q   <= n_head_d;
      n_tail_q   <= n_tail_d;
      p_count_q  <= p_count_d;
      n_count_q  <= n_count_d;
      status_q   <= status_d;
      was_prio_q <= was_prio_d;
    end
  end

  // Priority class store: write at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (p_wr) begin
      p_mem[p_tail_q] <= item_value_i;
    end
    if (p_rd) begin
      p_rdata_q <= p_mem[p_head_q];
    end
  end

  // Normal class store: write at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (n_wr) begin
      n_mem[n_tail_q] <= item_value_i;
    end
    if (n_rd) begin
      n_rdata_q <= n_mem[n_head_q];
    end
  end

  // Drive the result word
  assign status_o           = status_q;
  assign out_was_priority_o = (status_q == ST_EMPTY) ? 1'b0 : was_prio_q;
  assign out_value_o        = (status_q != ST_REMOVED) ? '0 :
                              (was_prio_q ? p_rdata_q : n_rdata_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_count_q <= CntFull) && (n_count_q <= CntFull))
    else $error("class count above depth");

  a_prio_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_rd |=> (p_count_q == $past(p_count_q) - 1'b1) && (status_q == ST_REMOVED)
             && was_prio_q)
    else $error("priority remove did not pop the priority class");

  a_normal_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (mode_i == MODE_REMOVE) && p_any) |=> $stable(n_count_q))
    else $error("normal class popped while priority class held words");

endmodule

`default_nettype wire

@@ rtl/core/two_class_priority_queue_unit.sv @@
// A word accepted at one clock edge has its result on the ports,
// with done_o high, during the next cycle.
// A new word is not taken while busy is high; busy is high during the response cycle.
// The receiver cannot stall: each result is present for exactly one cycle.
// Reset (rst_ni low, asynchronous): both classes empty, threshold set to 60;
// store contents are not cleared and are only read after being written.
`default_nettype none

module two_class_priority_queue_unit
  import tpq_pkg::*;
#(
  parameter int CLASS_DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               mode_i,
  input  wire logic signed [31:0] item_value_i,
  input  wire logic               cfg_we_i,
  input  wire logic signed [31:0] cfg_wdata_i,
  output logic                    done_o,
  output logic [1:0]              status_o,
  output logic signed [31:0]      out_value_o,
  output logic                    out_was_priority_o
);

  tpq_cmd_t cmd;

  tpq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  tpq_datapath #(
    .CLASS_DEPTH (CLASS_DEPTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .mode_i             (mode_i),
    .item_value_i       (item_value_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .status_o           (status_o),
    .out_value_o        (out_value_o),
    .out_was_priority_o (out_was_priority_o)
  );

endmodule

`default_nettype wire
